[hdl/onewire_master_bit_engine_assert.svh]
// ---------------------------------------------------------------------------
// onewire_master_bit_engine_assert.svh
// assertion macros used by the one-wire master rtl
// ---------------------------------------------------------------------------
`ifndef ONEWIRE_MASTER_BIT_ENGINE_ASSERT_SVH
`define ONEWIRE_MASTER_BIT_ENGINE_ASSERT_SVH

// same-cycle implication
`define OWM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OWM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/owm_pkg.sv]
// ---------------------------------------------------------------------------
// owm_pkg
// types, codes and helpers of the one-wire master bit engine
// ---------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

	// request codes
	localparam logic [2:0] REQ_TICK    = 3'd0;
	localparam logic [2:0] REQ_RESET   = 3'd1;
	localparam logic [2:0] REQ_WR_BYTE = 3'd2;
	localparam logic [2:0] REQ_RD_BYTE = 3'd3;
	localparam logic [2:0] REQ_WR_BIT  = 3'd4;
	localparam logic [2:0] REQ_RD_BIT  = 3'd5;

	// configuration register indexes
	localparam logic [2:0] CFG_RESET_LOW  = 3'd0;
	localparam logic [2:0] CFG_PRES_DELAY = 3'd1;
	localparam logic [2:0] CFG_PRES_WIN   = 3'd2;
	localparam logic [2:0] CFG_PRES_MIN   = 3'd3;
	localparam logic [2:0] CFG_SLOT_LOW   = 3'd4;
	localparam logic [2:0] CFG_SAMPLE_DLY = 3'd5;
	localparam logic [2:0] CFG_SLOT_HOLD  = 3'd6;
	localparam logic [2:0] CFG_RECOVERY   = 3'd7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int TIMER_W    = 10;

	// reset values of the timing registers
	localparam logic [9:0] RST_RESET_LOW  = 10'd600;
	localparam logic [7:0] RST_PRES_DELAY = 8'd15;
	localparam logic [9:0] RST_PRES_WIN   = 10'd500;
	localparam logic [9:0] RST_PRES_MIN   = 10'd60;
	localparam logic [3:0] RST_SLOT_LOW   = 4'd2;
	localparam logic [3:0] RST_SAMPLE_DLY = 4'd5;
	localparam logic [6:0] RST_SLOT_HOLD  = 7'd60;
	localparam logic [3:0] RST_RECOVERY   = 4'd2;

	localparam logic [9:0] LOW_CNT_MAX = 10'd1023;
	localparam logic [7:0] CRC_POLY    = 8'h8C;

	typedef enum logic [11:0] {
		PH_IDLE       = 12'b0000_0000_0001,
		PH_RST_LOW    = 12'b0000_0000_0010,
		PH_RST_WAIT   = 12'b0000_0000_0100,
		PH_RST_SAMPLE = 12'b0000_0000_1000,
		PH_WR_LOW     = 12'b0000_0001_0000,
		PH_WR_HOLD    = 12'b0000_0010_0000,
		PH_WR_REC     = 12'b0000_0100_0000,
		PH_RD_LOW     = 12'b0000_1000_0000,
		PH_RD_WAIT    = 12'b0001_0000_0000,
		PH_RD_SAMPLE  = 12'b0010_0000_0000,
		PH_RD_HOLD    = 12'b0100_0000_0000,
		PH_RD_REC     = 12'b1000_0000_0000
	} phase_t;

	typedef struct packed {
		logic [9:0] reset_low_us;
		logic [7:0] presence_delay_us;
		logic [9:0] presence_window_us;
		logic [9:0] presence_min_count;
		logic [3:0] slot_low_us;
		logic [3:0] sample_delay_us;
		logic [6:0] slot_hold_us;
		logic [3:0] recovery_us;
	} cfg_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] data_byte;
		logic       line_level;
	} item_t;

	typedef struct packed {
		logic       line_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] read_data;
		logic [7:0] crc_value;
		logic       cmd_rejected;
	} result_t;

	// dallas crc8, reflected, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[hdl/owm_if.sv]
// ---------------------------------------------------------------------------
// owm_if
// valid/ready channels of the one-wire master: requests, results, config
// ---------------------------------------------------------------------------
`default_nettype none

interface owm_req_if;
	import owm_pkg::*;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [7:0] data_byte;
	logic       line_level;
	modport source (output valid, req_type, data_byte, line_level, input ready);
	modport sink (input valid, req_type, data_byte, line_level, output ready);
endinterface

interface owm_res_if;
	import owm_pkg::*;
	logic       valid;
	logic       ready;
	logic       line_low;
	logic       busy_res;
	logic       done_res;
	logic       presence;
	logic [7:0] read_data;
	logic [7:0] crc_value;
	logic       cmd_rejected;
	modport source (output valid, line_low, busy_res, done_res, presence, read_data,
		crc_value, cmd_rejected, input ready);
	modport sink (input valid, line_low, busy_res, done_res, presence, read_data,
		crc_value, cmd_rejected, output ready);
endinterface

interface owm_cfg_if;
	import owm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

[hdl/onewire_master_bit_engine.sv]
// ---------------------------------------------------------------------------
// onewire_master_bit_engine
// one-wire bus master stepped by 1 us tick items and command items
// ---------------------------------------------------------------------------
//  channel  dir  beat carries
//  req      in   req_type, data_byte, line_level
//  res      out  line_low, busy_res, done_res, presence, read_data,
//                crc_value, cmd_rejected
//  cfg      in   reg_index, wdata (always ready)
//
//  one beat per cycle in and out while results are taken; a result passes
//  input register, then result register; bus state updates between them.
//  arst_n clears all bus state and returns timing registers to defaults.
//  a stalled result holds the update stage; the input register still takes
//  one more beat, then req.ready drops until the result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module onewire_master_bit_engine (
	input  wire logic clk,
	input  wire logic arst_n,
	owm_req_if.sink   req,
	owm_res_if.source res,
	owm_cfg_if.sink   cfg
);
	import owm_pkg::*;

	`include "onewire_master_bit_engine_assert.svh"

	item_t   item_s1;
	logic    vld_s1;
	logic    advance;
	cfg_t    regs;
	result_t step_res, res_q;
	logic    res_vld_q;

	assign advance   = vld_s1 && (!res_vld_q || res.ready);
	assign req.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.req_type   <= req.req_type;
			item_s1.data_byte  <= req.data_byte;
			item_s1.line_level <= req.line_level;
		end
	end

	owm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	owm_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.regs   (regs),
		.res    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= step_res;
	end

	assign res.valid        = res_vld_q;
	assign res.line_low     = res_q.line_low;
	assign res.busy_res     = res_q.busy_res;
	assign res.done_res     = res_q.done_res;
	assign res.presence     = res_q.presence;
	assign res.read_data    = res_q.read_data;
	assign res.crc_value    = res_q.crc_value;
	assign res.cmd_rejected = res_q.cmd_rejected;

	// a finished operation leaves the bus idle and released
	`OWM_ASSERT_NOW(a_done_idle, clk, arst_n, res_vld_q && res_q.done_res,
		!res_q.busy_res && !res_q.line_low, "done result still busy or driving")
	// rejection only happens with an operation in flight
	`OWM_ASSERT_NOW(a_rej_busy, clk, arst_n, res_vld_q && res_q.cmd_rejected,
		res_q.busy_res && !res_q.done_res, "rejected command while not busy")
	// a stalled update stage blocks the input
	`OWM_ASSERT_NOW(a_stall_blocks, clk, arst_n, vld_s1 && res_vld_q && !res.ready,
		!req.ready, "input taken while update stage stalled")
	// every update produces a waiting result
	`OWM_ASSERT_NEXT(a_adv_result, clk, arst_n, advance, res_vld_q,
		"update without result")

endmodule

`default_nettype wire

[hdl/owm_cfg.sv]
// ---------------------------------------------------------------------------
// owm_cfg
// timing register file written through the configuration channel
// ---------------------------------------------------------------------------
`default_nettype none

module owm_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	owm_cfg_if.sink            cfg,
	output owm_pkg::cfg_t      regs
);
	import owm_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.reset_low_us       <= RST_RESET_LOW;
			regs_q.presence_delay_us  <= RST_PRES_DELAY;
			regs_q.presence_window_us <= RST_PRES_WIN;
			regs_q.presence_min_count <= RST_PRES_MIN;
			regs_q.slot_low_us        <= RST_SLOT_LOW;
			regs_q.sample_delay_us    <= RST_SAMPLE_DLY;
			regs_q.slot_hold_us       <= RST_SLOT_HOLD;
			regs_q.recovery_us        <= RST_RECOVERY;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				CFG_RESET_LOW:  regs_q.reset_low_us       <= cfg.wdata;
				CFG_PRES_DELAY: regs_q.presence_delay_us  <= cfg.wdata[7:0];
				CFG_PRES_WIN:   regs_q.presence_window_us <= cfg.wdata;
				CFG_PRES_MIN:   regs_q.presence_min_count <= cfg.wdata;
				CFG_SLOT_LOW:   regs_q.slot_low_us        <= cfg.wdata[3:0];
				CFG_SAMPLE_DLY: regs_q.sample_delay_us    <= cfg.wdata[3:0];
				CFG_SLOT_HOLD:  regs_q.slot_hold_us       <= cfg.wdata[6:0];
				CFG_RECOVERY:   regs_q.recovery_us        <= cfg.wdata[3:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/owm_step.sv]
// ---------------------------------------------------------------------------
// owm_step
// bus state and combinational update for one tick or command
// ---------------------------------------------------------------------------
`default_nettype none

module owm_step (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire owm_pkg::item_t item,
	input  wire owm_pkg::cfg_t regs,
	output owm_pkg::result_t   res
);
	import owm_pkg::*;

	typedef struct packed {
		phase_t             phase;
		logic [TIMER_W-1:0] timer;
	} enter_t;

	phase_t             phase_q, phase_nxt;
	logic [TIMER_W-1:0] timer_q, timer_nxt, timer_dec;
	logic [2:0]         bit_q, bit_nxt;
	logic [7:0]         shift_q, shift_nxt;
	logic [9:0]         low_cnt_q, low_cnt_nxt;
	logic               pres_q, pres_nxt;
	logic [7:0]         crc_q, crc_nxt;
	logic               byte_mode_q, byte_mode_nxt;
	logic [7:0]         last_rd_q, last_rd_nxt;
	logic               is_cmd, done, rejected, drive;
	enter_t             ent;

	// phase entry with zero-length waits skipped, other zero lengths as one
	function automatic enter_t enter_phase(input phase_t ph, input cfg_t c);
		enter_t e;
		phase_t p;
		p = ph;
		if (p == PH_RST_WAIT && c.presence_delay_us == '0) p = PH_RST_SAMPLE;
		if (p == PH_RD_WAIT && c.sample_delay_us == '0) p = PH_RD_SAMPLE;
		e.phase = p;
		unique case (p)
			PH_RST_LOW:    e.timer = (c.reset_low_us == '0) ? 10'd1 : c.reset_low_us;
			PH_RST_WAIT:   e.timer = {2'b0, c.presence_delay_us};
			PH_RST_SAMPLE: e.timer = (c.presence_window_us == '0) ? 10'd1
				: c.presence_window_us;
			PH_WR_LOW, PH_RD_LOW:
				e.timer = (c.slot_low_us == '0) ? 10'd1 : {6'b0, c.slot_low_us};
			PH_WR_HOLD, PH_RD_HOLD:
				e.timer = (c.slot_hold_us == '0) ? 10'd1 : {3'b0, c.slot_hold_us};
			PH_RD_WAIT:    e.timer = {6'b0, c.sample_delay_us};
			PH_RD_SAMPLE:  e.timer = 10'd1;
			PH_WR_REC, PH_RD_REC:
				e.timer = (c.recovery_us == '0) ? 10'd1 : {6'b0, c.recovery_us};
			default: begin
				e.phase = PH_IDLE;
				e.timer = '0;
			end
		endcase
		return e;
	endfunction

	assign is_cmd = (item.req_type == REQ_RESET) || (item.req_type == REQ_WR_BYTE)
		|| (item.req_type == REQ_RD_BYTE) || (item.req_type == REQ_WR_BIT)
		|| (item.req_type == REQ_RD_BIT);
	assign timer_dec = (timer_q != '0) ? timer_q - 10'd1 : '0;

	always_comb begin
		phase_nxt     = phase_q;
		timer_nxt     = timer_q;
		bit_nxt       = bit_q;
		shift_nxt     = shift_q;
		low_cnt_nxt   = low_cnt_q;
		pres_nxt      = pres_q;
		crc_nxt       = crc_q;
		byte_mode_nxt = byte_mode_q;
		last_rd_nxt   = last_rd_q;
		done          = 1'b0;
		rejected      = 1'b0;
		ent           = enter_phase(PH_IDLE, regs);

		if (is_cmd) begin
			if (phase_q != PH_IDLE) begin
				rejected = 1'b1;
			end else begin
				bit_nxt = '0;
				unique case (item.req_type) inside
					REQ_RESET: begin
						crc_nxt     = '0;
						pres_nxt    = 1'b0;
						low_cnt_nxt = '0;
						ent         = enter_phase(PH_RST_LOW, regs);
					end
					REQ_WR_BYTE, REQ_WR_BIT: begin
						byte_mode_nxt = (item.req_type == REQ_WR_BYTE);
						shift_nxt     = (item.req_type == REQ_WR_BYTE) ? item.data_byte
							: {7'b0, item.data_byte[0]};
						ent           = enter_phase(PH_WR_LOW, regs);
					end
					default: begin
						byte_mode_nxt = (item.req_type == REQ_RD_BYTE);
						shift_nxt     = '0;
						ent           = enter_phase(PH_RD_LOW, regs);
					end
				endcase
				phase_nxt = ent.phase;
				timer_nxt = ent.timer;
			end
		end else if (phase_q != PH_IDLE) begin
			if (phase_q == PH_RST_SAMPLE && !item.line_level && low_cnt_q < LOW_CNT_MAX)
				low_cnt_nxt = low_cnt_q + 10'd1;
			if (phase_q == PH_RD_SAMPLE) begin
				if (byte_mode_q) shift_nxt = shift_q | ({7'b0, item.line_level} << bit_q);
				else last_rd_nxt = {7'b0, item.line_level};
			end
			timer_nxt = timer_dec;
			if (timer_dec == '0) begin
				unique case (phase_q)
					PH_RST_LOW:   ent = enter_phase(PH_RST_WAIT, regs);
					PH_RST_WAIT:  ent = enter_phase(PH_RST_SAMPLE, regs);
					PH_RST_SAMPLE: begin
						pres_nxt = (low_cnt_nxt > regs.presence_min_count);
						done     = 1'b1;
					end
					PH_WR_LOW:    ent = enter_phase(PH_WR_HOLD, regs);
					PH_WR_HOLD:   ent = enter_phase(PH_WR_REC, regs);
					PH_RD_LOW:    ent = enter_phase(PH_RD_WAIT, regs);
					PH_RD_WAIT:   ent = enter_phase(PH_RD_SAMPLE, regs);
					PH_RD_SAMPLE: ent = enter_phase(PH_RD_HOLD, regs);
					PH_RD_HOLD:   ent = enter_phase(PH_RD_REC, regs);
					PH_WR_REC, PH_RD_REC: begin
						// slot end: next bit of a byte, or finish
						if (byte_mode_q && bit_q != 3'd7) begin
							bit_nxt = bit_q + 3'd1;
							ent     = enter_phase((phase_q == PH_RD_REC) ? PH_RD_LOW
								: PH_WR_LOW, regs);
						end else begin
							done = 1'b1;
							if (phase_q == PH_RD_REC && byte_mode_q) begin
								last_rd_nxt = shift_q;
								crc_nxt     = crc8_byte(crc_q, shift_q);
							end
						end
					end
					default: ;
				endcase
				phase_nxt = ent.phase;
				timer_nxt = ent.timer;
			end
		end

		drive = 1'b0;
		if (phase_nxt == PH_RST_LOW || phase_nxt == PH_WR_LOW || phase_nxt == PH_RD_LOW)
			drive = 1'b1;
		else if (phase_nxt == PH_WR_HOLD)
			drive = ~shift_nxt[bit_nxt];
	end

	always_comb begin
		res.line_low     = drive;
		res.busy_res     = (phase_nxt != PH_IDLE);
		res.done_res     = done;
		res.presence     = pres_nxt;
		res.read_data    = last_rd_nxt;
		res.crc_value    = crc_nxt;
		res.cmd_rejected = rejected;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			timer_q     <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			low_cnt_q   <= '0;
			pres_q      <= 1'b0;
			crc_q       <= '0;
			byte_mode_q <= 1'b0;
			last_rd_q   <= '0;
		end else if (step) begin
			phase_q     <= phase_nxt;
			timer_q     <= timer_nxt;
			bit_q       <= bit_nxt;
			shift_q     <= shift_nxt;
			low_cnt_q   <= low_cnt_nxt;
			pres_q      <= pres_nxt;
			crc_q       <= crc_nxt;
			byte_mode_q <= byte_mode_nxt;
			last_rd_q   <= last_rd_nxt;
		end
	end

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the one-wire master bit engine
//
// Command and tick beats are queued by a directed sequence and then by
// random well-formed operations with rejected commands and unused codes
// mixed in. Each accepted request beat updates a cycle-free copy of the bus
// state. The result it predicts is checked field by field against the
// result beats, in order. Timing registers are rewritten between
// sequences: defaults, small, all-zero and threshold settings, then
// random ones. Both channels idle at random.
// ---------------------------------------------------------------------------
module tb;
	import owm_pkg::*;

	// codes with no operation behind them, handled as ticks
	localparam logic [2:0] REQ_UNUSED6 = 3'd6;
	localparam logic [2:0] REQ_UNUSED7 = 3'd7;

	logic clk;
	logic arst_n;

	owm_req_if req_ch ();
	owm_res_if res_ch ();
	owm_cfg_if cfg_ch ();

	onewire_master_bit_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	item_t   items_to_send[$];
	result_t bus_results_due[$];
	int      n_queued;
	int      n_accepted;
	int      n_results_seen;
	int      n_errors;

	// bus state as the block should hold it
	cfg_t       timing;
	phase_t     bus_phase;
	logic [9:0] phase_left;
	logic [2:0] slot_bit;
	logic [7:0] shift_bits;
	logic [9:0] low_samples;
	logic       presence_seen;
	logic [7:0] crc_acc;
	logic       whole_byte;
	logic [7:0] last_read;

	// driver and receiver pacing
	item_t   beat_in;
	item_t   next_item;
	result_t want;
	result_t got;
	result_t due;
	int      send_gap;
	int      send_calm;
	int      recv_stall;
	int      recv_calm;
	logic    recv_rdy;
	logic    long_hold_done;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("onewire_master_bit_engine regression: fail");
		$finish;
	end

	function automatic logic [9:0] min_one(input logic [9:0] v);
		return (v == '0) ? 10'd1 : v;
	endfunction

	function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] c;
		logic       lsb;
		c = acc ^ b;
		repeat (8) begin
			lsb = c[0];
			c = {1'b0, c[7:1]};
			if (lsb) c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function automatic void enter_phase(input phase_t p);
		phase_t q;
		q = p;
		// zero delays skip their wait entirely
		if (q == PH_RST_WAIT && timing.presence_delay_us == '0) q = PH_RST_SAMPLE;
		if (q == PH_RD_WAIT && timing.sample_delay_us == '0) q = PH_RD_SAMPLE;
		bus_phase = q;
		case (q)
			PH_RST_LOW:             phase_left = min_one(timing.reset_low_us);
			PH_RST_WAIT:            phase_left = 10'(timing.presence_delay_us);
			PH_RST_SAMPLE:          phase_left = min_one(timing.presence_window_us);
			PH_WR_LOW, PH_RD_LOW:   phase_left = min_one(10'(timing.slot_low_us));
			PH_WR_HOLD, PH_RD_HOLD: phase_left = min_one(10'(timing.slot_hold_us));
			PH_RD_WAIT:             phase_left = 10'(timing.sample_delay_us);
			PH_RD_SAMPLE:           phase_left = 10'd1;
			PH_WR_REC, PH_RD_REC:   phase_left = min_one(10'(timing.recovery_us));
			default: begin
				bus_phase = PH_IDLE;
				phase_left = '0;
			end
		endcase
	endfunction

	function automatic logic finish_slot(input logic reading);
		if (whole_byte && slot_bit < 3'd7) begin
			slot_bit = slot_bit + 3'd1;
			enter_phase(reading ? PH_RD_LOW : PH_WR_LOW);
			return 1'b0;
		end
		if (reading && whole_byte) begin
			last_read = shift_bits;
			crc_acc = crc_fold(crc_acc, shift_bits);
		end
		enter_phase(PH_IDLE);
		return 1'b1;
	endfunction

	function automatic logic tick_bus(input logic level);
		if (bus_phase == PH_IDLE) return 1'b0;
		if (bus_phase == PH_RST_SAMPLE && !level && low_samples < LOW_CNT_MAX)
			low_samples = low_samples + 10'd1;
		if (bus_phase == PH_RD_SAMPLE) begin
			if (whole_byte) shift_bits[slot_bit] = shift_bits[slot_bit] | level;
			else last_read = {7'd0, level};
		end
		if (phase_left != '0) phase_left = phase_left - 10'd1;
		if (phase_left != '0) return 1'b0;
		case (bus_phase)
			PH_RST_LOW:  enter_phase(PH_RST_WAIT);
			PH_RST_WAIT: enter_phase(PH_RST_SAMPLE);
			PH_RST_SAMPLE: begin
				presence_seen = (low_samples > timing.presence_min_count);
				enter_phase(PH_IDLE);
				return 1'b1;
			end
			PH_WR_LOW:    enter_phase(PH_WR_HOLD);
			PH_WR_HOLD:   enter_phase(PH_WR_REC);
			PH_WR_REC:    return finish_slot(1'b0);
			PH_RD_LOW:    enter_phase(PH_RD_WAIT);
			PH_RD_WAIT:   enter_phase(PH_RD_SAMPLE);
			PH_RD_SAMPLE: enter_phase(PH_RD_HOLD);
			PH_RD_HOLD:   enter_phase(PH_RD_REC);
			PH_RD_REC:    return finish_slot(1'b1);
			default:      enter_phase(PH_IDLE);
		endcase
		return 1'b0;
	endfunction

	function automatic result_t advance_master(input item_t it);
		result_t r;
		logic    done;
		r = '0;
		done = 1'b0;
		if (it.req_type >= REQ_RESET && it.req_type <= REQ_RD_BIT) begin
			if (bus_phase != PH_IDLE) begin
				r.cmd_rejected = 1'b1;
			end else begin
				slot_bit = '0;
				case (it.req_type)
					REQ_RESET: begin
						crc_acc = '0;
						presence_seen = 1'b0;
						low_samples = '0;
						enter_phase(PH_RST_LOW);
					end
					REQ_WR_BYTE, REQ_WR_BIT: begin
						whole_byte = (it.req_type == REQ_WR_BYTE);
						shift_bits = whole_byte ? it.data_byte : {7'd0, it.data_byte[0]};
						enter_phase(PH_WR_LOW);
					end
					default: begin
						whole_byte = (it.req_type == REQ_RD_BYTE);
						shift_bits = '0;
						enter_phase(PH_RD_LOW);
					end
				endcase
			end
		end else begin
			done = tick_bus(it.line_level);
		end
		if (bus_phase == PH_RST_LOW || bus_phase == PH_WR_LOW || bus_phase == PH_RD_LOW)
			r.line_low = 1'b1;
		else if (bus_phase == PH_WR_HOLD)
			r.line_low = ~shift_bits[slot_bit];
		r.busy_res = (bus_phase != PH_IDLE);
		r.done_res = done;
		r.presence = presence_seen;
		r.read_data = last_read;
		r.crc_value = crc_acc;
		return r;
	endfunction

	// ticks an operation needs under the current timing
	function automatic int op_ticks(input logic [2:0] kind);
		int wslot;
		int rslot;
		wslot = min_one(10'(timing.slot_low_us)) + min_one(10'(timing.slot_hold_us))
			+ min_one(10'(timing.recovery_us));
		rslot = wslot + timing.sample_delay_us + 1;
		case (kind)
			REQ_RESET: return min_one(timing.reset_low_us) + timing.presence_delay_us
				+ min_one(timing.presence_window_us);
			REQ_WR_BYTE: return 8 * wslot;
			REQ_RD_BYTE: return 8 * rslot;
			REQ_WR_BIT:  return wslot;
			default:     return rslot;
		endcase
	endfunction

	// mostly no gap, some short, a few long, now and then a calm stretch
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(99, 0);
		if (r < 2) begin
			calm = $urandom_range(120, 30);
			return 0;
		end
		if (r < 6) return $urandom_range(24, 8);
		if (r < 40) return $urandom_range(3, 1);
		return 0;
	endfunction

	task automatic push_item(input logic [2:0] kind, input logic [7:0] data, input logic level);
		item_t it;
		it.req_type = kind;
		it.data_byte = data;
		it.line_level = level;
		items_to_send.push_back(it);
		n_queued++;
	endtask

	// stray commands land only before the last tick, while the bus is busy
	task automatic push_ticks(input int n, input int low_pct, input int noise_pct);
		int         k;
		logic [2:0] code;
		k = 0;
		while (k < n) begin
			if ($urandom_range(99, 0) < noise_pct) begin
				push_item(3'($urandom_range(REQ_RD_BIT, REQ_RESET)), 8'($urandom), 1'($urandom));
			end else begin
				code = ($urandom_range(99, 0) < noise_pct) ?
					3'($urandom_range(REQ_UNUSED7, REQ_UNUSED6)) : REQ_TICK;
				push_item(code, 8'($urandom), $urandom_range(99, 0) >= low_pct);
				k++;
			end
		end
	endtask

	task automatic run_op(input logic [2:0] kind, input logic [7:0] data, input int low_pct,
		input int noise_pct);
		push_item(kind, data, 1'($urandom));
		push_ticks(op_ticks(kind), low_pct, noise_pct);
		push_ticks($urandom_range(2, 0), 50, 0);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [9:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_RESET_LOW:  timing.reset_low_us = value;
			CFG_PRES_DELAY: timing.presence_delay_us = value[7:0];
			CFG_PRES_WIN:   timing.presence_window_us = value;
			CFG_PRES_MIN:   timing.presence_min_count = value;
			CFG_SLOT_LOW:   timing.slot_low_us = value[3:0];
			CFG_SAMPLE_DLY: timing.sample_delay_us = value[3:0];
			CFG_SLOT_HOLD:  timing.slot_hold_us = value[6:0];
			default:        timing.recovery_us = value[3:0];
		endcase
	endtask

	task automatic set_timing(input logic [9:0] rl, input logic [9:0] pd, input logic [9:0] pw,
		input logic [9:0] pm, input logic [9:0] sl, input logic [9:0] sd, input logic [9:0] sh,
		input logic [9:0] rec);
		write_reg(CFG_RESET_LOW, rl);
		write_reg(CFG_PRES_DELAY, pd);
		write_reg(CFG_PRES_WIN, pw);
		write_reg(CFG_PRES_MIN, pm);
		write_reg(CFG_SLOT_LOW, sl);
		write_reg(CFG_SAMPLE_DLY, sd);
		write_reg(CFG_SLOT_HOLD, sh);
		write_reg(CFG_RECOVERY, rec);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		do @(posedge clk); while (n_accepted != n_queued || bus_results_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= REQ_TICK;
			req_ch.data_byte <= '0;
			req_ch.line_level <= 1'b1;
			send_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				beat_in = {req_ch.req_type, req_ch.data_byte, req_ch.line_level};
				want = advance_master(beat_in);
				bus_results_due.push_back(want);
				n_accepted++;
				send_gap = idle_len(send_calm);
			end
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (items_to_send.size() != 0) begin
					next_item = items_to_send.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= next_item.req_type;
					req_ch.data_byte <= next_item.data_byte;
					req_ch.line_level <= next_item.line_level;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result ready, with one long hold that backs the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			recv_stall = 0;
			long_hold_done = 1'b0;
		end else begin
			if (recv_stall != 0) begin
				recv_stall--;
				recv_rdy = 1'b0;
			end else if (!long_hold_done && n_results_seen >= 150) begin
				long_hold_done = 1'b1;
				recv_stall = 300;
				recv_rdy = 1'b0;
			end else begin
				recv_stall = idle_len(recv_calm);
				recv_rdy = (recv_stall == 0);
			end
			res_ch.ready <= recv_rdy;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			n_results_seen++;
			got = {res_ch.line_low, res_ch.busy_res, res_ch.done_res, res_ch.presence,
				res_ch.read_data, res_ch.crc_value, res_ch.cmd_rejected};
			if (bus_results_due.size() == 0) begin
				$error("result beat with no expectation pending");
				n_errors++;
			end else begin
				due = bus_results_due.pop_front();
				if (got.line_low !== due.line_low) begin
					$error("line_low exp %0d got %0d", due.line_low, got.line_low);
					n_errors++;
				end
				if (got.busy_res !== due.busy_res) begin
					$error("busy_res exp %0d got %0d", due.busy_res, got.busy_res);
					n_errors++;
				end
				if (got.done_res !== due.done_res) begin
					$error("done_res exp %0d got %0d", due.done_res, got.done_res);
					n_errors++;
				end
				if (got.presence !== due.presence) begin
					$error("presence exp %0d got %0d", due.presence, got.presence);
					n_errors++;
				end
				if (got.read_data !== due.read_data) begin
					$error("read_data exp %02h got %02h", due.read_data, got.read_data);
					n_errors++;
				end
				if (got.crc_value !== due.crc_value) begin
					$error("crc_value exp %02h got %02h", due.crc_value, got.crc_value);
					n_errors++;
				end
				if (got.cmd_rejected !== due.cmd_rejected) begin
					$error("cmd_rejected exp %0d got %0d", due.cmd_rejected, got.cmd_rejected);
					n_errors++;
				end
			end
		end
	end

	initial begin
		int         p;
		int         start;
		int         r;
		int         low_pct;
		logic [9:0] win;
		int         low_choices[5];

		low_choices = '{0, 10, 50, 90, 100};
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = CFG_RESET_LOW;
		cfg_ch.wdata = '0;
		n_queued = 0;
		n_accepted = 0;
		n_results_seen = 0;
		n_errors = 0;
		send_calm = 0;
		recv_calm = 0;
		timing.reset_low_us = RST_RESET_LOW;
		timing.presence_delay_us = RST_PRES_DELAY;
		timing.presence_window_us = RST_PRES_WIN;
		timing.presence_min_count = RST_PRES_MIN;
		timing.slot_low_us = RST_SLOT_LOW;
		timing.sample_delay_us = RST_SAMPLE_DLY;
		timing.slot_hold_us = RST_SLOT_HOLD;
		timing.recovery_us = RST_RECOVERY;
		bus_phase = PH_IDLE;
		phase_left = '0;
		slot_bit = '0;
		shift_bits = '0;
		low_samples = '0;
		presence_seen = 1'b0;
		crc_acc = '0;
		whole_byte = 1'b0;
		last_read = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// default timing: idle ticks and unused codes, then every command while busy
		push_item(REQ_TICK, 8'h00, 1'b0);
		push_item(REQ_UNUSED6, 8'hFF, 1'b1);
		push_item(REQ_UNUSED7, 8'h00, 1'b0);
		push_item(REQ_WR_BIT, 8'hFE, 1'b1);
		push_ticks(3, 50, 0);
		for (int c = REQ_RESET; c <= REQ_RD_BIT; c++) push_item(3'(c), 8'hFF, 1'b1);
		push_ticks(op_ticks(REQ_WR_BIT) - 3, 50, 0);
		drain();

		// short timing, crc accumulation, presence and crc clearing
		set_timing(10'd3, 10'd2, 10'd8, 10'd3, 10'd1, 10'd1, 10'd2, 10'd1);
		run_op(REQ_WR_BIT, 8'h01, 50, 0);
		run_op(REQ_RD_BYTE, 8'h00, 50, 0);
		run_op(REQ_RD_BYTE, 8'h00, 0, 0);
		run_op(REQ_RESET, 8'h00, 100, 0);
		run_op(REQ_RESET, 8'h00, 0, 0);
		run_op(REQ_RD_BIT, 8'h00, 50, 0);
		drain();

		// all zero: skipped delays, other lengths act as one tick
		set_timing('0, '0, '0, '0, '0, '0, '0, '0);
		run_op(REQ_RESET, 8'h00, 100, 0);
		run_op(REQ_RESET, 8'h00, 0, 0);
		run_op(REQ_RD_BYTE, 8'h00, 50, 0);
		run_op(REQ_WR_BYTE, 8'h5A, 50, 0);
		run_op(REQ_RD_BIT, 8'h00, 50, 0);
		run_op(REQ_WR_BIT, 8'h00, 50, 0);
		drain();

		// low count equal to the threshold is not presence, one above is
		set_timing(10'd2, 10'd0, 10'd4, 10'd4, 10'd1, 10'd0, 10'd1, 10'd1);
		run_op(REQ_RESET, 8'h00, 100, 0);
		drain();
		write_reg(CFG_PRES_MIN, 10'd3);
		cfg_ch.valid <= 1'b0;
		run_op(REQ_RESET, 8'h00, 100, 0);
		drain();

		// random timing with junk in the unused upper write bits
		for (p = 0; p < 2; p++) begin
			win = 10'($urandom_range(24, 0));
			set_timing(10'($urandom_range(24, 0)), {2'($urandom), 8'($urandom_range(6, 0))}, win,
				10'($urandom_range(win + 1, 0)), {6'($urandom), 4'($urandom_range(3, 0))},
				{6'($urandom), 4'($urandom_range(3, 0))}, {3'($urandom), 7'($urandom_range(4, 0))},
				{6'($urandom), 4'($urandom_range(3, 0))});
			start = n_queued;
			while (n_queued - start < 50) begin
				r = $urandom_range(99, 0);
				low_pct = low_choices[$urandom_range(4, 0)];
				if (r < 18) run_op(REQ_WR_BIT, 8'($urandom), low_pct, 5);
				else if (r < 36) run_op(REQ_RD_BIT, 8'($urandom), low_pct, 5);
				else if (r < 56) run_op(REQ_WR_BYTE, 8'($urandom), low_pct, 5);
				else if (r < 76) run_op(REQ_RD_BYTE, 8'($urandom), low_pct, 5);
				else if (r < 92) run_op(REQ_RESET, 8'($urandom), low_pct, 5);
				else begin
					repeat ($urandom_range(6, 1))
						push_item(($urandom_range(2, 0) == 0) ? REQ_TICK :
							3'($urandom_range(REQ_UNUSED7, REQ_UNUSED6)), 8'($urandom), 1'($urandom));
				end
			end
			drain();
		end

		if (n_errors == 0) begin
			$display("onewire_master_bit_engine regression: pass");
		end else begin
			$display("onewire_master_bit_engine regression: fail");
		end
		$finish;
	end

endmodule
